// File: src/uctp_pkg.sv
package uctp_pkg;

	// Width of the tick frame counter.
	localparam int unsigned CNT_W = 7;

	// Depth of the received character window.
	localparam int unsigned WIN_DEPTH = 7;

	// Request type codes.
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Frame characters.
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_B      = 8'h42;
	localparam logic [7:0] CH_W      = 8'h57;
	localparam logic [7:0] CH_H      = 8'h48;
	localparam logic [7:0] CH_Z      = 8'h5A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DASH   = 8'h2D;

	// ASCII code of the digit zero.
	localparam logic signed [11:0] DIGIT_ZERO = 12'sd48;

	// Send rate after reset.
	localparam logic [3:0] RATE_RESET = 4'd10;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_EVAL
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} dp_cmd_t;

	// True when v is a multiple of the constant k. Each candidate multiple is
	// compared on its own, so this folds into a small set of equality checks.
	function automatic logic is_mult(input logic [7:0] v, input int unsigned k);
		logic hit;
		hit = 1'b0;
		for (int unsigned i = 0; i < 256; i++) begin
			if ((i * k) < 256 && v == 8'(i * k)) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

// File: src/uctp_ctrl.sv
module uctp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output uctp_pkg::dp_cmd_t  cmd
);

	uctp_pkg::state_t state_q;
	uctp_pkg::state_t state_next;
	logic             out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uctp_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and datapath commands. An item is evaluated once the output
	// register is free or is being drained in the same cycle.
	always_comb begin
		state_next  = state_q;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		in_stall    = 1'b1;
		unique case (state_q)
			uctp_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_next  = uctp_pkg::ST_EVAL;
				end
			end
			uctp_pkg::ST_EVAL: begin
				if (!out_valid_q || !out_stall) begin
					cmd.commit = 1'b1;
					state_next = uctp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = uctp_pkg::ST_IDLE;
			end
		endcase
	end

	// Output valid flag: set by a commit, cleared when the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// An accepted transaction blocks the input until it has been evaluated.
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (in_stall && cmd.commit == 1'b0) || in_stall)
		else $error("input not blocked after an accepted transaction");

	// Every commit presents a result in the next cycle.
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("committed result not presented");

	// A commit never overwrites a result that is still held.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || !out_stall))
		else $error("held result overwritten");

	// Capture and commit never happen together.
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && cmd.commit))
		else $error("capture and commit in the same cycle");

endmodule

// File: src/uctp_dp.sv
module uctp_dp #(
	parameter int unsigned FRAME_TICKS = 100
) (
	input  logic               clk,
	input  logic               arst_n,
	input  uctp_pkg::dp_cmd_t  cmd,
	input  logic               req_type,
	input  logic signed [7:0]  received_char,
	output logic               bandwidth_request,
	output logic [3:0]         bandwidth_value,
	output logic               rate_updated,
	output logic               command_error,
	output logic               led_level,
	output logic               sample_accel,
	output logic               send_accel,
	output logic               send_attitude
);

	localparam logic [uctp_pkg::CNT_W-1:0] LastTick = uctp_pkg::CNT_W'(FRAME_TICKS);

	logic                        req_type_q;
	logic [7:0]                  char_q;
	logic [7:0]                  win_q [uctp_pkg::WIN_DEPTH];
	logic [7:0]                  win_next [uctp_pkg::WIN_DEPTH];
	logic [uctp_pkg::CNT_W-1:0]  counter_q;
	logic [uctp_pkg::CNT_W-1:0]  counter_next;
	logic [3:0]                  rate_q;
	logic                        led_q;
	logic                        led_next;

	logic                        frame_ok;
	logic                        is_bw;
	logic                        is_hz;
	logic signed [11:0]          d1_v;
	logic signed [11:0]          d2_v;
	logic signed [11:0]          value;
	logic                        bw_ok;
	logic                        hz_ok;
	logic                        bw_req_c;
	logic                        rate_upd_c;
	logic                        err_c;
	logic                        sample_c;
	logic                        send_acc_c;
	logic                        send_att_c;

	logic                        bw_req_q;
	logic [3:0]                  bw_val_q;
	logic                        rate_upd_q;
	logic                        err_q;
	logic                        led_out_q;
	logic                        sample_q;
	logic                        send_acc_q;
	logic                        send_att_q;

	// Input capture register.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q <= req_type;
			char_q     <= received_char;
		end
	end

	// Window after shifting in the captured byte, newest at entry zero.
	always_comb begin
		win_next[0] = char_q;
		for (int i = 1; i < uctp_pkg::WIN_DEPTH; i++) begin
			win_next[i] = win_q[i-1];
		end
	end

	// Frame match and digit value: (d1 - 48) * 10 + (d2 - 48) on signed bytes.
	always_comb begin
		frame_ok = win_next[6] == uctp_pkg::CH_DOLLAR && win_next[3] == uctp_pkg::CH_COMMA &&
			win_next[0] == uctp_pkg::CH_STAR;
		is_bw = win_next[5] == uctp_pkg::CH_B && win_next[4] == uctp_pkg::CH_W;
		is_hz = win_next[5] == uctp_pkg::CH_H && win_next[4] == uctp_pkg::CH_Z;
		d1_v  = {{4{win_next[2][7]}}, win_next[2]} - uctp_pkg::DIGIT_ZERO;
		d2_v  = {{4{win_next[1][7]}}, win_next[1]} - uctp_pkg::DIGIT_ZERO;
		value = (d1_v <<< 3) + (d1_v <<< 1) + d2_v;
		bw_ok = value >= 12'sd8 && value <= 12'sd15;
		hz_ok = value == 12'sd0 || value == 12'sd1 || value == 12'sd2 ||
			value == 12'sd5 || value == 12'sd10;
	end

	// Result of the current item.
	always_comb begin
		bw_req_c     = 1'b0;
		rate_upd_c   = 1'b0;
		err_c        = 1'b0;
		sample_c     = 1'b0;
		send_acc_c   = 1'b0;
		send_att_c   = 1'b0;
		led_next     = led_q;
		counter_next = counter_q;
		if (req_type_q == uctp_pkg::REQ_BYTE) begin
			if (frame_ok && is_bw) begin
				bw_req_c = bw_ok;
				err_c    = !bw_ok;
			end else if (frame_ok && is_hz) begin
				rate_upd_c = hz_ok;
				err_c      = !hz_ok;
			end
		end else begin
			if (uctp_pkg::is_mult(8'(counter_q) + 8'd6, 50)) begin
				led_next = !led_q;
			end
			sample_c = counter_q[0];
			case (rate_q)
				4'd1:    send_acc_c = uctp_pkg::is_mult(8'(counter_q), 100);
				4'd2:    send_acc_c = uctp_pkg::is_mult(8'(counter_q), 50);
				4'd5:    send_acc_c = uctp_pkg::is_mult(8'(counter_q), 20);
				4'd10:   send_acc_c = uctp_pkg::is_mult(8'(counter_q), 10);
				default: send_acc_c = 1'b0;
			endcase
			send_att_c = uctp_pkg::is_mult(8'(counter_q) + 8'd3, 20);
			if (counter_q == LastTick) begin
				counter_next = uctp_pkg::CNT_W'(1);
			end else begin
				counter_next = counter_q + uctp_pkg::CNT_W'(1);
			end
		end
	end

	// Block state, updated when an item is committed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < uctp_pkg::WIN_DEPTH; i++) begin
				win_q[i] <= uctp_pkg::CH_DASH;
			end
			counter_q <= '0;
			rate_q    <= uctp_pkg::RATE_RESET;
			led_q     <= 1'b0;
		end else if (cmd.commit) begin
			if (req_type_q == uctp_pkg::REQ_BYTE) begin
				win_q <= win_next;
			end
			if (rate_upd_c) begin
				rate_q <= value[3:0];
			end
			counter_q <= counter_next;
			led_q     <= led_next;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			bw_req_q   <= bw_req_c;
			bw_val_q   <= bw_req_c ? value[3:0] : 4'd0;
			rate_upd_q <= rate_upd_c;
			err_q      <= err_c;
			led_out_q  <= led_next;
			sample_q   <= sample_c;
			send_acc_q <= send_acc_c;
			send_att_q <= send_att_c;
		end
	end

	assign bandwidth_request = bw_req_q;
	assign bandwidth_value   = bw_val_q;
	assign rate_updated      = rate_upd_q;
	assign command_error     = err_q;
	assign led_level         = led_out_q;
	assign sample_accel      = sample_q;
	assign send_accel        = send_acc_q;
	assign send_attitude     = send_att_q;

	// The frame counter never passes the frame length.
	a_counter_range: assert property (@(posedge clk) disable iff (!arst_n)
		counter_q <= LastTick)
		else $error("frame counter out of range");

	// The send rate only ever holds one of the accepted rates.
	a_rate_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rate_q == 4'd0 || rate_q == 4'd1 || rate_q == 4'd2 || rate_q == 4'd5 ||
		rate_q == 4'd10)
		else $error("illegal send rate");

endmodule

// File: src/uart_command_parser_and_tick_scheduler.sv
// An accepted transaction is captured into the input register, then committed into the
// output register once that is free or being drained, and presented to the receiver.
// The controller evaluates one item at a time and takes no new one until the last is
// committed; evaluation waits while a held result is stalled at the output.
// Reset (arst_n low, asynchronous): window filled with '-', frame counter 0,
// send rate 10, LED off, no result pending.
module uart_command_parser_and_tick_scheduler #(
	parameter int unsigned FRAME_TICKS = 100
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              req_type,
	input  logic signed [7:0] received_char,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              bandwidth_request,
	output logic [3:0]        bandwidth_value,
	output logic              rate_updated,
	output logic              command_error,
	output logic              led_level,
	output logic              sample_accel,
	output logic              send_accel,
	output logic              send_attitude
);

	uctp_pkg::dp_cmd_t cmd;

	// Controller: handshakes and sequencing.
	uctp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Datapath: window, frame parser, tick scheduler and output register.
	uctp_dp #(
		.FRAME_TICKS (FRAME_TICKS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.req_type          (req_type),
		.received_char     (received_char),
		.bandwidth_request (bandwidth_request),
		.bandwidth_value   (bandwidth_value),
		.rate_updated      (rate_updated),
		.command_error     (command_error),
		.led_level         (led_level),
		.sample_accel      (sample_accel),
		.send_accel        (send_accel),
		.send_attitude     (send_attitude)
	);

endmodule

// File: tb/frame_tick_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the UART command parser and tick scheduler, keeps
// its own copy of the parser and scheduler state, and compares every result
// transaction against the oldest predicted one.
module frame_tick_checker #(
	parameter int unsigned FRAME_TICKS = 100
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              req_type,
	input  logic signed [7:0] received_char,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              bandwidth_request,
	input  logic [3:0]        bandwidth_value,
	input  logic              rate_updated,
	input  logic              command_error,
	input  logic              led_level,
	input  logic              sample_accel,
	input  logic              send_accel,
	input  logic              send_attitude,
	output int                results_due,
	output int                mismatches
);

	localparam int TICKS_PER_SECOND = 100;
	localparam int LED_PERIOD       = 50;
	localparam int LED_OFFSET       = 6;
	localparam int ATT_PERIOD       = 20;
	localparam int ATT_OFFSET       = 3;

	typedef struct packed {
		logic       bw_req;
		logic [3:0] bw_val;
		logic       rate_upd;
		logic       err;
		logic       led;
		logic       sample;
		logic       send_acc;
		logic       send_att;
	} sched_result_t;

	// Shadow copy of the block state.
	logic [7:0]                 window [uctp_pkg::WIN_DEPTH];
	logic [uctp_pkg::CNT_W-1:0] tick_count;
	logic [3:0]                 rate;
	logic                       led;

	sched_result_t expected_results [$];

	// Applies one item to the shadow state and returns the result it should give.
	function automatic sched_result_t predict_item(input logic kind, input logic [7:0] ch);
		sched_result_t r;
		int value;
		int c;
		r = '0;
		if (kind == uctp_pkg::REQ_BYTE) begin
			for (int i = uctp_pkg::WIN_DEPTH - 1; i > 0; i--) begin
				window[i] = window[i - 1];
			end
			window[0] = ch;
			if (window[6] == uctp_pkg::CH_DOLLAR && window[3] == uctp_pkg::CH_COMMA &&
				window[0] == uctp_pkg::CH_STAR) begin
				value = ($signed(window[2]) - uctp_pkg::DIGIT_ZERO) * 10
					+ ($signed(window[1]) - uctp_pkg::DIGIT_ZERO);
				if (window[5] == uctp_pkg::CH_B && window[4] == uctp_pkg::CH_W) begin
					if (value >= 8 && value <= 15) begin
						r.bw_req = 1'b1;
						r.bw_val = 4'(value);
					end else begin
						r.err = 1'b1;
					end
				end else if (window[5] == uctp_pkg::CH_H && window[4] == uctp_pkg::CH_Z) begin
					if (value inside {0, 1, 2, 5, 10}) begin
						rate = 4'(value);
						r.rate_upd = 1'b1;
					end else begin
						r.err = 1'b1;
					end
				end
			end
		end else begin
			// The strobes come from the counter value before it advances.
			c = int'(tick_count);
			if ((c + LED_OFFSET) % LED_PERIOD == 0) begin
				led = ~led;
			end
			r.sample = tick_count[0];
			if (rate != 0 && c % (TICKS_PER_SECOND / int'(rate)) == 0) begin
				r.send_acc = 1'b1;
			end
			if ((c + ATT_OFFSET) % ATT_PERIOD == 0) begin
				r.send_att = 1'b1;
			end
			if (c == FRAME_TICKS) begin
				c = 0;
			end
			tick_count = uctp_pkg::CNT_W'(c + 1);
		end
		r.led = led;
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Results are checked before the new transaction is predicted, so a result
	// can never be matched against an item accepted at the same edge.
	always @(posedge clk or negedge arst_n) begin
		sched_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < uctp_pkg::WIN_DEPTH; i++) begin
				window[i] = uctp_pkg::CH_DASH;
			end
			tick_count = '0;
			rate = uctp_pkg::RATE_RESET;
			led = 1'b0;
			expected_results.delete();
			results_due = 0;
			mismatches = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result transaction, expected none, actual %b",
						$time, {bandwidth_request, bandwidth_value, rate_updated,
						command_error, led_level, sample_accel, send_accel, send_attitude});
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("bandwidth_request", want.bw_req, bandwidth_request);
					check_field("bandwidth_value", want.bw_val, bandwidth_value);
					check_field("rate_updated", want.rate_upd, rate_updated);
					check_field("command_error", want.err, command_error);
					check_field("led_level", want.led, led_level);
					check_field("sample_accel", want.sample, sample_accel);
					check_field("send_accel", want.send_acc, send_accel);
					check_field("send_attitude", want.send_att, send_attitude);
				end
			end
			if (in_valid && !in_stall) begin
				expected_results.push_back(predict_item(req_type, received_char));
			end
			results_due = expected_results.size();
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int unsigned FRAME_TICKS = 100;
	localparam int ITEM_TARGET   = 1200;
	localparam int HOLD_AT       = 300;
	localparam int HOLD_CYCLES   = 80;
	localparam int PAUSE_AT      = 700;
	localparam int QUIET_FROM    = 800;
	localparam int QUIET_TO      = 1000;
	localparam int IDLE_PERCENT  = 12;
	localparam int STALL_LIMIT   = 2000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              req_type = uctp_pkg::REQ_BYTE;
	logic signed [7:0] received_char = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              bandwidth_request;
	logic [3:0]        bandwidth_value;
	logic              rate_updated;
	logic              command_error;
	logic              led_level;
	logic              sample_accel;
	logic              send_accel;
	logic              send_attitude;

	int results_due;
	int mismatches;
	int items_sent = 0;
	int idle_cycles = 0;
	int hold_left = 0;
	bit held_once = 1'b0;

	always #1 clk = ~clk;

	uart_command_parser_and_tick_scheduler #(
		.FRAME_TICKS(FRAME_TICKS)
	) DUT (.*);

	frame_tick_checker #(
		.FRAME_TICKS(FRAME_TICKS)
	) checker_inst (.*);

	function automatic bit quiet_stretch();
		return items_sent >= QUIET_FROM && items_sent < QUIET_TO;
	endfunction

	// Offers one transaction, sometimes after a short random gap.
	task automatic send_item(input logic kind, input logic [7:0] ch);
		if (!quiet_stretch() && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		received_char <= ch;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] ch);
		send_item(uctp_pkg::REQ_BYTE, ch);
	endtask

	task automatic send_tick();
		send_item(uctp_pkg::REQ_TICK, 8'($urandom));
	endtask

	// Sends the first count characters of a command, with one optionally replaced.
	task automatic send_command(input logic [7:0] k1, input logic [7:0] k2,
			input logic [7:0] d1, input logic [7:0] d2, input int count, input int bad_pos);
		logic [7:0] text [7];
		text = '{uctp_pkg::CH_DOLLAR, k1, k2, uctp_pkg::CH_COMMA, d1, d2,
			uctp_pkg::CH_STAR};
		if (bad_pos >= 0) begin
			text[bad_pos] = 8'($urandom);
		end
		for (int i = 0; i < count; i++) begin
			send_byte(text[i]);
		end
	endtask

	function automatic logic [7:0] tens_char(input int v);
		return 8'(uctp_pkg::DIGIT_ZERO + v / 10);
	endfunction

	function automatic logic [7:0] ones_char(input int v);
		return 8'(uctp_pkg::DIGIT_ZERO + v % 10);
	endfunction

	// A random BW or HZ command; mostly in-range values, some out of range,
	// some with arbitrary bytes in the digit or key positions.
	task automatic random_command(input bit broken);
		int rates [5];
		logic [7:0] k1, k2, d1, d2;
		int v, sel, count, bad_pos;
		bit is_bw;
		rates = '{0, 1, 2, 5, 10};
		is_bw = $urandom_range(1);
		k1 = is_bw ? uctp_pkg::CH_B : uctp_pkg::CH_H;
		k2 = is_bw ? uctp_pkg::CH_W : uctp_pkg::CH_Z;
		if ($urandom_range(99) < 5) begin
			k1 = 8'($urandom);
			k2 = 8'($urandom);
		end
		sel = $urandom_range(99);
		if (sel < 50) begin
			v = is_bw ? $urandom_range(15, 8) : rates[$urandom_range(4)];
		end else begin
			v = $urandom_range(99);
		end
		d1 = tens_char(v);
		d2 = ones_char(v);
		if (sel >= 80) begin
			d1 = 8'($urandom);
			d2 = 8'($urandom);
		end
		count = 7;
		bad_pos = -1;
		if (broken) begin
			if ($urandom_range(1)) begin
				count = $urandom_range(6, 1);
			end else begin
				bad_pos = $urandom_range(6);
			end
		end
		send_command(k1, k2, d1, d2, count, bad_pos);
	endtask

	// Drops valid and waits until the block has delivered every result.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (results_due == 0);
		@(posedge clk);
	endtask

	// Receiver: random stalls, one long hold-off once traffic is under way,
	// and no stalls during the quiet stretch.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (!held_once && items_sent >= HOLD_AT) begin
			held_once = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (quiet_stretch()) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	// Watchdog on cycles without any accepted transaction.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int r;
		bit paused = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: byte extremes, smallest bandwidth, rate of zero, then ticks
		// from a zero counter with accelerometer sends suppressed.
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_command(uctp_pkg::CH_B, uctp_pkg::CH_W, tens_char(8), ones_char(8), 7, -1);
		send_command(uctp_pkg::CH_H, uctp_pkg::CH_Z, tens_char(0), ones_char(0), 7, -1);
		repeat (4) send_tick();

		// Random: mostly ticks and well-formed commands, some noise and broken ones.
		while (items_sent < ITEM_TARGET) begin
			if (!paused && items_sent >= PAUSE_AT) begin
				paused = 1'b1;
				drain();
			end
			r = $urandom_range(99);
			if (r < 45) begin
				send_tick();
			end else if (r < 85) begin
				random_command(1'b0);
			end else if (r < 93) begin
				random_command(1'b1);
			end else begin
				send_byte(8'($urandom));
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
